### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL; empty under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
`define ASSERT_CLK_NORST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_CLK_NORST(lbl, clk, prop, msg)
`endif

`endif

### rtl/bdph_pkg.sv
// ----------------------------------------------------------------------------
// bdph_pkg
// Types and constants of the button debouncer with press and hold reporting.
// ----------------------------------------------------------------------------
`default_nettype none

package bdph_pkg;

    localparam int TIME_W     = 32;
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 1;
    localparam int RAW_W      = 3;
    localparam int IDX_W      = 2;
    localparam int MASK_W     = 3;

    // s_tdata layout
    localparam int NOW_LSB    = 0;
    localparam int RAW_LSB    = NOW_LSB + TIME_W;
    localparam int IDX_LSB    = RAW_LSB + RAW_W;
    localparam int DUR_LSB    = IDX_LSB + IDX_W;
    localparam int S_FIELDS_W = DUR_LSB + TIME_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;

    // m_tdata layout
    localparam int M_FIELDS_W = 3 + MASK_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE_MS  = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_STALE_GAP_MS = CFG_ADDR_W'(1);

    localparam logic [CFG_W-1:0] DEBOUNCE_MS_RST  = CFG_W'(50);
    localparam logic [CFG_W-1:0] STALE_GAP_MS_RST = CFG_W'(500);

    typedef enum logic {
        MODE_SAMPLE = 1'b0,
        MODE_QUERY  = 1'b1
    } mode_t;

    typedef struct packed {
        mode_t             mode;
        logic [TIME_W-1:0] now_ms;
        logic [RAW_W-1:0]  raw_buttons;
        logic [IDX_W-1:0]  button_index;
        logic [TIME_W-1:0] hold_duration_ms;
    } item_t;

    typedef struct packed {
        logic [MASK_W-1:0] stable_mask;
        logic              hold_event;
        logic              held_now;
        logic              press_event;
    } result_t;

endpackage

`default_nettype wire

### rtl/button_debounce_press_hold.sv
// Input transfers enter the input register, then the result register on m_tvalid.
// Throughput: one item per cycle while m_tready does not stall the output; input
// register and result register form a two-stage pipeline, per-button state is read
// and updated in stage two. Reset (aresetn low, synchronous): all button state and
// timestamps cleared, debounce_ms = 50, stale_gap_ms = 500, both stages empty.
// ----------------------------------------------------------------------------
// button_debounce_press_hold
// Multi-button debouncer with stale-gap bypass, press latch and hold report.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module button_debounce_press_hold #(
    parameter int NUM_BUTTONS = 3
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                cfg_wr_en,
    input  wire logic [bdph_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [bdph_pkg::CFG_W-1:0]          cfg_wdata,

    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // now_ms[31:0], raw_buttons[34:32], button_index[36:35],
    // hold_duration_ms[68:37], zero pad
    input  wire logic [bdph_pkg::S_TDATA_W-1:0]      s_tdata,
    // mode[0]
    input  wire logic                                s_tuser,

    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // press_event[0], held_now[1], hold_event[2], stable_mask[5:3], zero pad
    output logic [bdph_pkg::M_TDATA_W-1:0]           m_tdata
);

    import bdph_pkg::*;

    logic [CFG_W-1:0]  debounce_reg;
    logic [CFG_W-1:0]  stale_gap_reg;

    logic              in_valid_reg, in_valid_next;
    item_t             item_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           result_reg, result_next;

    logic [NUM_BUTTONS-1:0] stable_reg, stable_next;
    logic [NUM_BUTTONS-1:0] last_raw_reg, last_raw_next;
    logic [NUM_BUTTONS-1:0] latch_reg, latch_next;
    logic [NUM_BUTTONS-1:0] hold_rep_reg, hold_rep_next;
    logic [TIME_W-1:0]      change_time_reg [NUM_BUTTONS];
    logic [TIME_W-1:0]      change_time_next [NUM_BUTTONS];
    logic [TIME_W-1:0]      press_time_reg [NUM_BUTTONS];
    logic [TIME_W-1:0]      press_time_next [NUM_BUTTONS];
    logic [TIME_W-1:0]      last_sample_reg, last_sample_next;

    logic                   advance;
    logic                   proc_fire;
    logic                   in_fire;
    logic                   stale;
    logic [NUM_BUTTONS+RAW_W-1:0]  raw_ext;
    logic [NUM_BUTTONS+MASK_W-1:0] mask_ext;

    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign in_fire   = s_tvalid && s_tready;
    assign proc_fire = in_valid_reg && advance;

    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {(M_TDATA_W - M_FIELDS_W)'(0), result_reg};

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg  <= DEBOUNCE_MS_RST;
            stale_gap_reg <= STALE_GAP_MS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_DEBOUNCE_MS:  debounce_reg  <= cfg_wdata;
                REG_STALE_GAP_MS: stale_gap_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // pipeline control
    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_fire) begin
            in_valid_next = 1'b1;
        end else if (proc_fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (proc_fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            item_reg.mode             <= mode_t'(s_tuser);
            item_reg.now_ms           <= s_tdata[NOW_LSB +: TIME_W];
            item_reg.raw_buttons      <= s_tdata[RAW_LSB +: RAW_W];
            item_reg.button_index     <= s_tdata[IDX_LSB +: IDX_W];
            item_reg.hold_duration_ms <= s_tdata[DUR_LSB +: TIME_W];
        end
        if (proc_fire) begin
            result_reg <= result_next;
        end
    end

    // per-button update
    assign stale   = (item_reg.now_ms - last_sample_reg) > {(TIME_W - CFG_W)'(0), stale_gap_reg};
    assign raw_ext = {NUM_BUTTONS'(0), item_reg.raw_buttons};

    always_comb begin
        stable_next      = stable_reg;
        last_raw_next    = last_raw_reg;
        latch_next       = latch_reg;
        hold_rep_next    = hold_rep_reg;
        change_time_next = change_time_reg;
        press_time_next  = press_time_reg;
        last_sample_next = last_sample_reg;
        result_next.press_event = 1'b0;
        result_next.held_now    = 1'b0;
        result_next.hold_event  = 1'b0;

        if (item_reg.mode == MODE_SAMPLE) begin
            last_sample_next = item_reg.now_ms;
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                if (stale || raw_ext[b] != last_raw_reg[b]) begin
                    last_raw_next[b]    = raw_ext[b];
                    change_time_next[b] = item_reg.now_ms;
                end
                if ((stale && raw_ext[b] != stable_reg[b]) ||
                    (!stale && raw_ext[b] == last_raw_reg[b] &&
                     raw_ext[b] != stable_reg[b] &&
                     (item_reg.now_ms - change_time_reg[b]) >=
                         {(TIME_W - CFG_W)'(0), debounce_reg})) begin
                    stable_next[b] = raw_ext[b];
                    if (raw_ext[b]) begin
                        latch_next[b]      = 1'b1;
                        press_time_next[b] = item_reg.now_ms;
                        hold_rep_next[b]   = 1'b0;
                    end
                end
            end
        end else begin
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                if (b == int'(item_reg.button_index)) begin
                    result_next.press_event = latch_reg[b];
                    latch_next[b]           = 1'b0;
                    result_next.held_now    = stable_reg[b];
                    if (stable_reg[b] && !hold_rep_reg[b] &&
                        (item_reg.now_ms - press_time_reg[b]) >=
                            item_reg.hold_duration_ms) begin
                        hold_rep_next[b]       = 1'b1;
                        result_next.hold_event = 1'b1;
                    end
                end
            end
        end

        mask_ext                = {MASK_W'(0), stable_next};
        result_next.stable_mask = mask_ext[MASK_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stable_reg      <= '0;
            last_raw_reg    <= '0;
            latch_reg       <= '0;
            hold_rep_reg    <= '0;
            last_sample_reg <= '0;
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                change_time_reg[b] <= '0;
                press_time_reg[b]  <= '0;
            end
        end else if (proc_fire) begin
            stable_reg      <= stable_next;
            last_raw_reg    <= last_raw_next;
            latch_reg       <= latch_next;
            hold_rep_reg    <= hold_rep_next;
            last_sample_reg <= last_sample_next;
            change_time_reg <= change_time_next;
            press_time_reg  <= press_time_next;
        end
    end

    `ASSERT_CLK(a_sample_no_flags, aclk, aresetn,
        (proc_fire && item_reg.mode == MODE_SAMPLE) |=> (m_tdata[2:0] == 3'b000),
        "sample transfer produced query flags")
    `ASSERT_CLK(a_hold_implies_held, aclk, aresetn,
        m_tvalid |-> !(m_tdata[2] && !m_tdata[1]),
        "hold_event without held_now")
    `ASSERT_CLK(a_stable_only_on_sample, aclk, aresetn,
        !(proc_fire && item_reg.mode == MODE_SAMPLE) |=> $stable(stable_reg),
        "debounced levels changed outside a sample transfer")

endmodule

`default_nettype wire
